// ===== rtl/assert_macros.svh =====
// Assertion shorthands for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define SFBP_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define SFBP_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sfbp_pkg.sv =====
package sfbp_pkg;

  localparam int MAX_BYTES      = 256;
  localparam int MAX_RESOLUTION = 24;
  localparam int VAL_W          = 48;
  localparam int RES_W          = 5;
  localparam int BYTE_W         = 8;
  localparam int QUOT_W         = MAX_RESOLUTION;
  localparam int PROD_W         = VAL_W + QUOT_W;
  localparam int ACC_W          = MAX_RESOLUTION + BYTE_W;
  localparam int ACC_CNT_W      = $clog2(ACC_W);
  localparam int SHIFT_W        = ACC_CNT_W + 1;
  localparam int STEP_W         = $clog2(QUOT_W);
  localparam int CNT_W          = $clog2(MAX_BYTES + 1);
  localparam int FRAME_BYTES_W  = 9;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_RES   = 2'd1,
    ST_BAD_RANGE = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_SCALE,
    S_DIV,
    S_ROUND,
    S_MERGE,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] field_value;
    logic signed [VAL_W-1:0] range_min;
    logic signed [VAL_W-1:0] range_max;
    logic [RES_W-1:0]        bit_count;
    logic                    frame_end;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]        packed_byte;
    logic                     byte_valid;
    logic                     frame_done;
    status_t                  status;
    logic [FRAME_BYTES_W-1:0] frame_bytes;
  } out_item_t;

endpackage

// ===== rtl/scaled_field_bit_packer.sv =====
// Telemetry field quantizer and MSB-first bit packer. Each accepted item is
// clamped to [range_min, range_max], scaled to round((2^bit_count-1)*(v-min)/
// (max-min)) with half-up rounding, and its bit_count bits are appended to the
// frame's bit stream; each finished byte leaves as one result item, and the
// last field of a frame flushes a zero-padded partial byte and reports the
// byte total on its final result. Each item goes through accept,
// check/clamp, scale, 24 restoring-division steps, round and merge, and
// then emits its result items (possibly none), waiting out any output
// stall; a field that fails its resolution or range check goes from
// accept and check straight to emitting its results. The division
// steps run through a single 49-bit compare/subtract unit, which also
// decides the rounding. in_ready is high only while the block is idle.
// Bytes past the 256th of a frame are dropped and reported with
// overflow status.
module scaled_field_bit_packer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sfbp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sfbp_pkg::out_item_t out_data
);

  sfbp_pkg::state_t state_r, state_nxt;

  // Latched item and working registers of the quantizer.
  sfbp_pkg::in_item_t                item_r, item_nxt;
  logic [sfbp_pkg::VAL_W-1:0]        d_r, d_nxt;
  logic [sfbp_pkg::VAL_W-1:0]        range_r, range_nxt;
  logic [sfbp_pkg::VAL_W-1:0]        rem_r, rem_nxt;
  logic [sfbp_pkg::QUOT_W-1:0]       low_r, low_nxt;
  logic [sfbp_pkg::QUOT_W-1:0]       quot_r, quot_nxt;
  logic [sfbp_pkg::STEP_W-1:0]       step_r, step_nxt;

  // Bit stream accumulator, left aligned; holds the pending partial byte
  // between items.
  logic [sfbp_pkg::ACC_W-1:0]        acc_r, acc_nxt;
  logic [sfbp_pkg::ACC_CNT_W-1:0]    cnt_r, cnt_nxt;

  // Frame bookkeeping.
  logic [sfbp_pkg::CNT_W-1:0]        bytes_r, bytes_nxt;
  logic                              ovf_r, ovf_nxt;
  logic                              err_pend_r, err_pend_nxt;
  sfbp_pkg::status_t                 err_code_r, err_code_nxt;

  // Output register.
  logic                              out_valid_r, out_valid_nxt;
  sfbp_pkg::out_item_t               out_r, out_nxt;

  // Shared compare/subtract unit.
  logic                              div_bit;
  logic [sfbp_pkg::VAL_W:0]          trial;
  logic [sfbp_pkg::VAL_W:0]          trial_diff;
  logic                              trial_ge;

  // Check and clamp.
  logic                              bad_res;
  logic                              bad_range;
  logic signed [sfbp_pkg::VAL_W-1:0] v_clamp;

  // Scale and merge.
  logic [sfbp_pkg::PROD_W-1:0]       prod;
  logic [sfbp_pkg::SHIFT_W-1:0]      merge_sh;
  logic [sfbp_pkg::ACC_W-1:0]        q_ext;

  // Result selection.
  logic                              slot_free;
  logic                              acc_full;
  logic                              has_res;
  logic [sfbp_pkg::ACC_CNT_W-1:0]    cnt_after;
  logic                              final_res;
  logic                              drop;
  logic                              ovf_after;
  logic [sfbp_pkg::CNT_W-1:0]        bytes_after;

  assign in_ready  = (state_r == sfbp_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // One restoring-division step: shift in a bit and try to subtract.
  assign div_bit    = (state_r == sfbp_pkg::S_DIV) ? low_r[sfbp_pkg::QUOT_W-1] : 1'b0;
  assign trial      = {rem_r, div_bit};
  assign trial_ge   = (trial >= {1'b0, range_r});
  assign trial_diff = trial - {1'b0, range_r};

  assign bad_res   = (item_r.bit_count == '0) ||
                     (item_r.bit_count > sfbp_pkg::RES_W'(sfbp_pkg::MAX_RESOLUTION));
  assign bad_range = (item_r.range_max <= item_r.range_min);
  assign v_clamp   = (item_r.field_value < item_r.range_min) ? item_r.range_min :
                     (item_r.field_value > item_r.range_max) ? item_r.range_max :
                     item_r.field_value;

  // (2^r - 1) * d as a shift and subtract.
  assign prod = ({{sfbp_pkg::QUOT_W{1'b0}}, d_r} << item_r.bit_count) -
                {{sfbp_pkg::QUOT_W{1'b0}}, d_r};

  assign merge_sh = sfbp_pkg::SHIFT_W'(sfbp_pkg::ACC_W) - {1'b0, cnt_r} -
                    sfbp_pkg::SHIFT_W'(item_r.bit_count);
  assign q_ext    = {{(sfbp_pkg::ACC_W - sfbp_pkg::QUOT_W){1'b0}}, quot_r};

  assign slot_free = !out_valid_r || out_ready;
  assign acc_full  = (cnt_r >= sfbp_pkg::ACC_CNT_W'(sfbp_pkg::BYTE_W));
  assign has_res   = err_pend_r || acc_full || (item_r.frame_end && (cnt_r != '0));
  assign cnt_after = err_pend_r ? cnt_r :
                     acc_full   ? cnt_r - sfbp_pkg::ACC_CNT_W'(sfbp_pkg::BYTE_W) : '0;
  assign final_res = !((cnt_after >= sfbp_pkg::ACC_CNT_W'(sfbp_pkg::BYTE_W)) ||
                       (item_r.frame_end && (cnt_after != '0)));
  assign drop        = !err_pend_r && (bytes_r == sfbp_pkg::CNT_W'(sfbp_pkg::MAX_BYTES));
  assign ovf_after   = ovf_r || drop;
  assign bytes_after = (!err_pend_r && !drop) ? bytes_r + 1'b1 : bytes_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sfbp_pkg::S_IDLE: begin
        if (in_valid) state_nxt = sfbp_pkg::S_PREP;
      end
      sfbp_pkg::S_PREP: begin
        state_nxt = (bad_res || bad_range) ? sfbp_pkg::S_EMIT : sfbp_pkg::S_SCALE;
      end
      sfbp_pkg::S_SCALE: state_nxt = sfbp_pkg::S_DIV;
      sfbp_pkg::S_DIV: begin
        if (step_r == sfbp_pkg::STEP_W'(sfbp_pkg::QUOT_W - 1)) state_nxt = sfbp_pkg::S_ROUND;
      end
      sfbp_pkg::S_ROUND: state_nxt = sfbp_pkg::S_MERGE;
      sfbp_pkg::S_MERGE: state_nxt = sfbp_pkg::S_EMIT;
      sfbp_pkg::S_EMIT: begin
        if (!has_res || (slot_free && final_res)) state_nxt = sfbp_pkg::S_IDLE;
      end
      default: state_nxt = sfbp_pkg::S_IDLE;
    endcase
  end

  // Datapath and result generation.
  always_comb begin
    item_nxt      = item_r;
    d_nxt         = d_r;
    range_nxt     = range_r;
    rem_nxt       = rem_r;
    low_nxt       = low_r;
    quot_nxt      = quot_r;
    step_nxt      = step_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    bytes_nxt     = bytes_r;
    ovf_nxt       = ovf_r;
    err_pend_nxt  = err_pend_r;
    err_code_nxt  = err_code_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;

    unique case (state_r)
      sfbp_pkg::S_IDLE: begin
        if (in_valid) item_nxt = in_data;
      end
      sfbp_pkg::S_PREP: begin
        d_nxt     = sfbp_pkg::VAL_W'(v_clamp - item_r.range_min);
        range_nxt = sfbp_pkg::VAL_W'(item_r.range_max - item_r.range_min);
        if (bad_res) begin
          err_pend_nxt = 1'b1;
          err_code_nxt = sfbp_pkg::ST_BAD_RES;
        end else if (bad_range) begin
          err_pend_nxt = 1'b1;
          err_code_nxt = sfbp_pkg::ST_BAD_RANGE;
        end
      end
      sfbp_pkg::S_SCALE: begin
        // The quotient fits in QUOT_W bits, so the upper product bits are
        // already below the range and seed the remainder.
        rem_nxt  = prod[sfbp_pkg::PROD_W-1:sfbp_pkg::QUOT_W];
        low_nxt  = prod[sfbp_pkg::QUOT_W-1:0];
        quot_nxt = '0;
        step_nxt = '0;
      end
      sfbp_pkg::S_DIV: begin
        rem_nxt  = trial_ge ? trial_diff[sfbp_pkg::VAL_W-1:0] : trial[sfbp_pkg::VAL_W-1:0];
        quot_nxt = {quot_r[sfbp_pkg::QUOT_W-2:0], trial_ge};
        low_nxt  = {low_r[sfbp_pkg::QUOT_W-2:0], 1'b0};
        step_nxt = step_r + 1'b1;
      end
      sfbp_pkg::S_ROUND: begin
        // 2*rem >= range rounds half up.
        quot_nxt = quot_r + sfbp_pkg::QUOT_W'(trial_ge);
      end
      sfbp_pkg::S_MERGE: begin
        acc_nxt = acc_r | (q_ext << merge_sh);
        cnt_nxt = cnt_r + sfbp_pkg::ACC_CNT_W'(item_r.bit_count);
      end
      sfbp_pkg::S_EMIT: begin
        if (has_res && slot_free) begin
          out_valid_nxt       = 1'b1;
          out_nxt.packed_byte = '0;
          out_nxt.byte_valid  = 1'b0;
          out_nxt.frame_done  = 1'b0;
          out_nxt.status      = sfbp_pkg::ST_OK;
          out_nxt.frame_bytes = '0;
          if (err_pend_r) begin
            err_pend_nxt   = 1'b0;
            out_nxt.status = err_code_r;
          end else begin
            if (drop) begin
              out_nxt.status = sfbp_pkg::ST_OVERFLOW;
            end else begin
              out_nxt.packed_byte = acc_r[sfbp_pkg::ACC_W-1 -: sfbp_pkg::BYTE_W];
              out_nxt.byte_valid  = 1'b1;
            end
            // Advance past a full byte, or drop the flushed partial byte.
            acc_nxt = acc_full ? (acc_r << sfbp_pkg::BYTE_W) : '0;
            cnt_nxt = cnt_after;
          end
          bytes_nxt = bytes_after;
          ovf_nxt   = ovf_after;
          if (final_res && item_r.frame_end) begin
            out_nxt.frame_done  = 1'b1;
            out_nxt.frame_bytes = sfbp_pkg::FRAME_BYTES_W'(bytes_after);
            if (ovf_after && (out_nxt.status == sfbp_pkg::ST_OK)) begin
              out_nxt.status = sfbp_pkg::ST_OVERFLOW;
            end
            // Start the next frame clean.
            acc_nxt   = '0;
            cnt_nxt   = '0;
            bytes_nxt = '0;
            ovf_nxt   = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sfbp_pkg::S_IDLE;
      acc_r       <= '0;
      cnt_r       <= '0;
      bytes_r     <= '0;
      ovf_r       <= 1'b0;
      err_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
      bytes_r     <= bytes_nxt;
      ovf_r       <= ovf_nxt;
      err_pend_r  <= err_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    d_r        <= d_nxt;
    range_r    <= range_nxt;
    rem_r      <= rem_nxt;
    low_r      <= low_nxt;
    quot_r     <= quot_nxt;
    step_r     <= step_nxt;
    err_code_r <= err_code_nxt;
    out_r      <= out_nxt;
  end

endmodule

// ===== rtl/sfbp_checker.sv =====
`include "assert_macros.svh"

module sfbp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input sfbp_pkg::out_item_t out_data
);

  `SFBP_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

  `SFBP_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "ready right after accepting an item")

  `SFBP_ASSERT_IMP(a_nobyte_status, clk, rst_n, out_valid && !out_data.byte_valid, out_data.status != sfbp_pkg::ST_OK, "result without byte reports ok")

  `SFBP_ASSERT_IMP(a_count_on_done, clk, rst_n, out_valid && !out_data.frame_done, out_data.frame_bytes == '0, "byte count outside frame end")

endmodule

bind scaled_field_bit_packer sfbp_checker u_sfbp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
